[hw/rtl/tcce_pkg.sv]
// Shared types, codes and constants for the text console cursor engine.
// Used by the top level, tcce_front and tcce_back; depends on nothing else.
`default_nettype none

package tcce_pkg;

  localparam int POS_W     = 12;
  localparam int COLOR_W   = 24;
  localparam int CODE_W    = 8;
  localparam int SCALE_W   = 3;
  localparam int SCALE_MAX = 5;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;
  localparam int TAB_STEPS = 4;

  localparam int DEF_GLYPH_WIDTH   = 8;
  localparam int DEF_GLYPH_HEIGHT  = 16;
  localparam int DEF_TEXT_CAPACITY = 4096;
  localparam int DEF_CMD_DEPTH     = 4;
  localparam int DEF_RES_DEPTH     = 4;

  localparam logic [POS_W-1:0]   RST_SCREEN_WIDTH  = 12'd1024;
  localparam logic [POS_W-1:0]   RST_SCREEN_HEIGHT = 12'd768;
  localparam logic [SCALE_W-1:0] RST_FONT_SCALE    = 3'd1;
  localparam logic [COLOR_W-1:0] RST_BACKGROUND    = 24'd0;

  localparam logic [CODE_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CODE_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CODE_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CODE_W-1:0] CH_SPACE     = 8'd32;
  localparam logic [CODE_W-1:0] CH_TILDE     = 8'd126;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_FONT_SCALE    = 2'd2,
    REG_BACKGROUND    = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_DRAW       = 2'd0,
    CMD_CLEAR_CELL = 2'd1,
    CMD_SCROLL     = 2'd2,
    CMD_FILL       = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OP_CLEAR   = 3'd0,
    OP_NEWLINE = 3'd1,
    OP_BKSP    = 3'd2,
    OP_TAB     = 3'd3,
    OP_PRINT   = 3'd4
  } op_kind_t;

  typedef struct packed {
    logic                action;
    logic [CODE_W-1:0]   char_code;
    logic [COLOR_W-1:0]  text_color;
  } request_t;

  typedef struct packed {
    cmd_t                command;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [CODE_W-1:0]   glyph_code;
    logic [COLOR_W-1:0]  paint_color;
    logic                last_result;
  } result_t;

  typedef struct packed {
    op_kind_t            kind;
    logic [CODE_W-1:0]   char_code;
    logic [COLOR_W-1:0]  text_color;
  } op_t;

  typedef struct packed {
    logic [POS_W-1:0]    screen_width;
    logic [POS_W-1:0]    screen_height;
    logic [SCALE_W-1:0]  font_scale;
    logic [COLOR_W-1:0]  background_color;
  } cfg_t;

endpackage

`default_nettype wire

[hw/rtl/text_console_cursor_engine.sv]
// Text console cursor engine, top level: configuration registers and the two queues.
// Depends on tcce_pkg, tcce_front, tcce_fifo and tcce_back.
//
// Requests enter through push/full; one transfer happens at each rising edge
// with push high and full low. A request is a character to write or a clear
// screen. Unknown characters are taken and dropped. Results leave through
// empty/pop; the oldest result sits on the result port while empty is low and
// is transferred at an edge with pop high. The last result of a request has
// last_result set; a request may cause none.
// Operations wait in a small queue in front of the execution sequencer, which
// takes one step per cycle while the result queue is not full: clear, newline
// and backspace are a single step, a printable character a draw step and then a
// wrap step, and a tab TAB_STEPS steps, each drawing a space or wrapping. A result
// passes through the operation queue, the sequencer's held-back result register
// and the result queue before it reaches the result port.
// If pop stays low, the result queue fills, the sequencer halts, the operation
// queue fills, and full rises; nothing is lost.
// Reset (rst, synchronous) homes the cursor, zeroes the stored count, empties
// both queues and loads the register defaults: width 1024, height 768,
// scale 1, background black. The user must write the registers over the APB port
// only while no request is in flight; the block itself does not enforce this.
`default_nettype none

module text_console_cursor_engine import tcce_pkg::*; #(
  parameter int GLYPH_WIDTH   = DEF_GLYPH_WIDTH,
  parameter int GLYPH_HEIGHT  = DEF_GLYPH_HEIGHT,
  parameter int TEXT_CAPACITY = DEF_TEXT_CAPACITY,
  parameter int CMD_DEPTH     = DEF_CMD_DEPTH,
  parameter int RES_DEPTH     = DEF_RES_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire request_t          request,
  output logic                   empty,
  input  wire logic              pop,
  output result_t                result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  cfg_t     cfg;
  reg_idx_t reg_sel;
  logic     reg_wr;

  logic     q_full;
  logic     enq;
  op_t      front_op;
  logic [$bits(op_t)-1:0] q_head;
  logic     q_empty;
  logic     op_pop;

  logic     res_full;
  logic     res_push;
  result_t  res_item;
  logic [$bits(result_t)-1:0] res_head;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width     <= RST_SCREEN_WIDTH;
      cfg.screen_height    <= RST_SCREEN_HEIGHT;
      cfg.font_scale       <= RST_FONT_SCALE;
      cfg.background_color <= RST_BACKGROUND;
    end else if (reg_wr) begin
      case (reg_sel)
        REG_SCREEN_WIDTH:  cfg.screen_width     <= pwdata[POS_W-1:0];
        REG_SCREEN_HEIGHT: cfg.screen_height    <= pwdata[POS_W-1:0];
        REG_FONT_SCALE:    cfg.font_scale       <= pwdata[SCALE_W-1:0];
        REG_BACKGROUND:    cfg.background_color <= pwdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SCREEN_WIDTH:  prdata = DATA_W'(cfg.screen_width);
      REG_SCREEN_HEIGHT: prdata = DATA_W'(cfg.screen_height);
      REG_FONT_SCALE:    prdata = DATA_W'(cfg.font_scale);
      REG_BACKGROUND:    prdata = DATA_W'(cfg.background_color);
      default:           prdata = '0;
    endcase
  end

  tcce_front u_front (
    .push    (push),
    .request (request),
    .full    (full),
    .q_full  (q_full),
    .enq     (enq),
    .op      (front_op)
  );

  tcce_fifo #(
    .WIDTH ($bits(op_t)),
    .DEPTH (CMD_DEPTH)
  ) u_op_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (enq),
    .wdata (front_op),
    .rd    (op_pop),
    .rdata (q_head),
    .full  (q_full),
    .empty (q_empty)
  );

  tcce_back #(
    .GLYPH_WIDTH   (GLYPH_WIDTH),
    .GLYPH_HEIGHT  (GLYPH_HEIGHT),
    .TEXT_CAPACITY (TEXT_CAPACITY)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .op       (op_t'(q_head)),
    .op_valid (!q_empty),
    .op_pop   (op_pop),
    .out_full (res_full),
    .out_push (res_push),
    .out_item (res_item)
  );

  tcce_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_push),
    .wdata (res_item),
    .rd    (pop),
    .rdata (res_head),
    .full  (res_full),
    .empty (empty)
  );

  assign result = result_t'(res_head);

endmodule

`default_nettype wire

[hw/rtl/tcce_fifo.sv]
// Small synchronous queue used between the front and back parts and on the result side.
// Depends on nothing but its parameters.
`default_nettype none

module tcce_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             rd,
  output logic [WIDTH-1:0]      rdata,
  output logic                  full,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tcce_front.sv]
// Front part: accepts requests and classifies them into queued operations.
// Depends on tcce_pkg.
`default_nettype none

module tcce_front import tcce_pkg::*; (
  input  wire logic     push,
  input  wire request_t request,
  output logic          full,
  input  wire logic     q_full,
  output logic          enq,
  output op_t           op
);

  logic printable;
  logic known;

  assign full      = q_full;
  assign printable = (request.char_code >= CH_SPACE) && (request.char_code <= CH_TILDE);

  // Characters that are not understood are still transferred in, but never queued.
  always_comb begin
    known         = 1'b1;
    op.char_code  = request.char_code;
    op.text_color = request.text_color;
    op.kind       = OP_PRINT;
    if (request.action == ACT_CLEAR) begin
      op.kind = OP_CLEAR;
    end else if (request.char_code == CH_NEWLINE) begin
      op.kind = OP_NEWLINE;
    end else if (request.char_code == CH_BACKSPACE) begin
      op.kind = OP_BKSP;
    end else if (request.char_code == CH_TAB) begin
      op.kind = OP_TAB;
    end else if (!printable) begin
      known = 1'b0;
    end
  end

  assign enq = push && !q_full && known;

endmodule

`default_nettype wire

[hw/rtl/tcce_back.sv]
// Back part: executes queued operations one step per cycle unless out_full is
// high, owns cursor and stored count, emits draw commands. Depends on tcce_pkg.
`default_nettype none

module tcce_back import tcce_pkg::*; #(
  parameter int GLYPH_WIDTH   = DEF_GLYPH_WIDTH,
  parameter int GLYPH_HEIGHT  = DEF_GLYPH_HEIGHT,
  parameter int TEXT_CAPACITY = DEF_TEXT_CAPACITY
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire op_t  op,
  input  wire logic op_valid,
  output logic      op_pop,
  input  wire logic out_full,
  output logic      out_push,
  output result_t   out_item
);

  localparam int CW_W     = $clog2(GLYPH_WIDTH * SCALE_MAX + 1);
  localparam int CH_W     = $clog2(GLYPH_HEIGHT * SCALE_MAX + 1);
  localparam int CNT_W    = $clog2(TEXT_CAPACITY + 1);
  localparam int CNT_DROP = TEXT_CAPACITY / 4;
  localparam int SUM_W    = POS_W + 1;

  logic [POS_W-1:0]   cx, cx_next;
  logic [POS_W-1:0]   cy, cy_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [1:0]         step, step_next;
  result_t            pend;
  logic               pend_v;
  logic               pend_fin;

  logic [SCALE_W-1:0] sc;
  logic [CW_W-1:0]    cw;
  logic [CH_W-1:0]    ch;
  logic               go;
  logic               final_step;
  logic               new_valid;
  result_t            new_res;
  result_t            scroll_res;
  logic [SUM_W-1:0]   x_adv;
  logic               fits;
  logic [SUM_W-1:0]   y_adv;
  logic [SUM_W:0]     y_chk;
  logic               scroll;
  logic [POS_W-1:0]   y_nl;
  logic [POS_W-1:0]   x_back;

  function automatic logic [CNT_W-1:0] store_one(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] t;
    t = c;
    if (t >= CNT_W'(TEXT_CAPACITY - 1)) begin
      t = t - CNT_W'(CNT_DROP);
    end
    if (t < CNT_W'(TEXT_CAPACITY)) begin
      t = t + 1'b1;
    end
    return t;
  endfunction

  always_comb begin
    if (cfg.font_scale == '0) begin
      sc = SCALE_W'(1);
    end else if (cfg.font_scale > SCALE_W'(SCALE_MAX)) begin
      sc = SCALE_W'(SCALE_MAX);
    end else begin
      sc = cfg.font_scale;
    end
  end

  assign cw = CW_W'(GLYPH_WIDTH) * CW_W'(sc);
  assign ch = CH_W'(GLYPH_HEIGHT) * CH_W'(sc);

  assign x_adv  = SUM_W'(cx) + SUM_W'(cw);
  assign fits   = x_adv <= SUM_W'(cfg.screen_width);
  assign x_back = cx - POS_W'(cw);

  // Moving down one text line: if the line after that would not fit, scroll
  // instead and leave the cursor row where it was.
  assign y_adv  = SUM_W'(cy) + SUM_W'(ch);
  assign y_chk  = (SUM_W + 1)'(y_adv) + (SUM_W + 1)'(ch);
  assign scroll = y_chk > (SUM_W + 1)'(cfg.screen_height);
  assign y_nl   = scroll ? cy : y_adv[POS_W-1:0];

  always_comb begin
    scroll_res             = '0;
    scroll_res.command     = CMD_SCROLL;
    scroll_res.paint_color = cfg.background_color;
  end

  assign go = op_valid && !out_full;

  always_comb begin
    cx_next    = cx;
    cy_next    = cy;
    cnt_next   = cnt;
    new_valid  = 1'b0;
    new_res    = '0;
    final_step = 1'b1;
    if (go) begin
      case (op.kind)
        OP_CLEAR: begin
          new_valid           = 1'b1;
          new_res.command     = CMD_FILL;
          new_res.paint_color = cfg.background_color;
          cx_next             = '0;
          cy_next             = '0;
          cnt_next            = '0;
        end
        OP_NEWLINE: begin
          cnt_next  = store_one(cnt);
          cx_next   = '0;
          cy_next   = y_nl;
          new_valid = scroll;
          new_res   = scroll_res;
        end
        OP_BKSP: begin
          if ((cnt != '0) && (cx >= POS_W'(cw))) begin
            cx_next             = x_back;
            cnt_next            = cnt - 1'b1;
            new_valid           = 1'b1;
            new_res.command     = CMD_CLEAR_CELL;
            new_res.pos_x       = x_back;
            new_res.pos_y       = cy;
            new_res.paint_color = cfg.background_color;
          end
        end
        OP_TAB: begin
          final_step = (step == 2'(TAB_STEPS - 1));
          if (fits) begin
            cnt_next            = store_one(cnt);
            cx_next             = x_adv[POS_W-1:0];
            new_valid           = 1'b1;
            new_res.command     = CMD_DRAW;
            new_res.pos_x       = cx;
            new_res.pos_y       = cy;
            new_res.glyph_code  = CH_SPACE;
            new_res.paint_color = op.text_color;
          end else begin
            cx_next   = '0;
            cy_next   = y_nl;
            new_valid = scroll;
            new_res   = scroll_res;
          end
        end
        OP_PRINT: begin
          if (step == 2'd0) begin
            final_step          = 1'b0;
            cnt_next            = store_one(cnt);
            // Saturate so that an advance past the last column still wraps.
            cx_next             = x_adv[POS_W] ? '1 : x_adv[POS_W-1:0];
            new_valid           = 1'b1;
            new_res.command     = CMD_DRAW;
            new_res.pos_x       = cx;
            new_res.pos_y       = cy;
            new_res.glyph_code  = op.char_code;
            new_res.paint_color = op.text_color;
          end else if (!fits) begin
            cx_next   = '0;
            cy_next   = y_nl;
            new_valid = scroll;
            new_res   = scroll_res;
          end
        end
        default: begin
          final_step = 1'b1;
        end
      endcase
    end
  end

  assign step_next = (go && !final_step) ? step + 1'b1 : (go ? 2'd0 : step);
  assign op_pop    = go && final_step;

  // A result is held back until the next result or its operation's final step,
  // so that its last_result flag is known when it is transferred out.
  assign out_push = !out_full && pend_v && (pend_fin || new_valid);

  always_comb begin
    out_item             = pend;
    out_item.last_result = pend_fin;
  end

  always_ff @(posedge clk) begin
    if (new_valid) begin
      pend <= new_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cx       <= '0;
      cy       <= '0;
      cnt      <= '0;
      step     <= '0;
      pend_v   <= 1'b0;
      pend_fin <= 1'b0;
    end else begin
      cx   <= cx_next;
      cy   <= cy_next;
      cnt  <= cnt_next;
      step <= step_next;
      if (new_valid) begin
        pend_v   <= 1'b1;
        pend_fin <= final_step;
      end else if (out_push) begin
        pend_v   <= 1'b0;
        pend_fin <= 1'b0;
      end else if (go && final_step && pend_v) begin
        pend_fin <= 1'b1;
      end
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    out_push |-> !out_full)
    else $error("result pushed into a full queue");

  a_fin_held: assert property (@(posedge clk) disable iff (rst)
    pend_fin |-> pend_v)
    else $error("final flag set without a held result");

  a_clear_home: assert property (@(posedge clk) disable iff (rst)
    (go && op.kind == OP_CLEAR) |=> (cx == '0 && cy == '0 && cnt == '0))
    else $error("clear screen did not home the cursor");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(TEXT_CAPACITY))
    else $error("stored count above capacity");

endmodule

`default_nettype wire
